// ----- hdl/integer_alu_multiwidth_top_assert.svh -----
// Assertion macros for the multi-width integer ALU checker.
// Used by the checker file only; depends on nothing else.
`ifndef INTEGER_ALU_MULTIWIDTH_TOP_ASSERT_SVH
`define INTEGER_ALU_MULTIWIDTH_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define IALU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent a fixed number of cycles later.
`define IALU_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- hdl/ialu_pkg.sv -----
// Package for the multi-width integer ALU: operation codes, pipeline beat type,
// latency constants and width helper functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ialu_pkg;
	localparam int DIV_STAGES = 64;
	localparam int LATENCY = DIV_STAGES + 4;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_SDIV = 5'd3, OP_SMOD = 5'd4,
		OP_UDIV = 5'd5, OP_UMOD = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
		OP_SHL = 5'd10, OP_SHR = 5'd11, OP_SAR = 5'd12, OP_EQ = 5'd13, OP_SGT = 5'd14,
		OP_SLT = 5'd15, OP_UGT = 5'd16, OP_ULT = 5'd17, OP_BOR = 5'd18, OP_BAND = 5'd19,
		OP_TOBOOL = 5'd20, OP_NEG = 5'd21, OP_NOT = 5'd22, OP_BNOT = 5'd23,
		OP_ZEXT = 5'd24, OP_SEXT = 5'd25
	} ialu_mode_t;

	typedef enum logic [1:0] {
		KIND_SCONST = 2'd0, KIND_UCONST = 2'd1, KIND_PLACE = 2'd2, KIND_OTHER = 2'd3
	} ialu_kind_t;

	typedef enum logic [1:0] {
		ST_FOLDED = 2'd0, ST_PLACEHOLDER = 2'd1, ST_NOT_FOLDED = 2'd2
	} ialu_status_t;

	typedef enum logic [1:0] {
		SZ_8 = 2'd0, SZ_16 = 2'd1, SZ_32 = 2'd2, SZ_64 = 2'd3
	} ialu_size_t;

	typedef enum logic [1:0] {
		SEL_SIMPLE = 2'd0, SEL_MUL = 2'd1, SEL_QUO = 2'd2, SEL_REM = 2'd3
	} ialu_sel_t;

	typedef struct packed {
		logic         valid;
		ialu_status_t status;
		logic         uns;
		ialu_sel_t    sel;
		logic         q_neg;
		logic         r_neg;
		ialu_size_t   size;
		logic [63:0]  simple;
		logic [63:0]  lt;
		logic [63:0]  rt;
		logic [63:0]  dvd;
		logic [63:0]  dvs;
	} ialu_op_t;

	function automatic logic [63:0] sx32(input logic [63:0] v);
		sx32 = {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] promote_wrap(input logic [63:0] v, input ialu_size_t sz);
		unique case (sz)
			SZ_8, SZ_16: promote_wrap = sx32(v);
			SZ_32:       promote_wrap = {32'd0, v[31:0]};
			default:     promote_wrap = v;
		endcase
	endfunction
endpackage
`default_nettype wire

// ----- hdl/ialu_decode.sv -----
// First pipeline stage: operand masking, status, simple results and divider setup.
// Depends on ialu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ialu_decode (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [4:0]       mode,
	input  wire logic [1:0]       size,
	input  wire logic [1:0]       left_kind,
	input  wire logic [1:0]       right_kind,
	input  wire logic [63:0]      left_value,
	input  wire logic [63:0]      right_value,
	output ialu_pkg::ialu_op_t    op_s1
);
	import ialu_pkg::*;

	logic [63:0] m, r_eff, lt, rt, ls, rs, min_s, ma, mb, res;
	logic [5:0] c;
	logic binary, is_sdiv, is_udiv, ovf;
	ialu_size_t sz;
	ialu_op_t nxt;

	always_comb begin
		sz = ialu_size_t'(size);
		binary = (mode <= OP_BAND);
		r_eff = (binary && right_kind == KIND_PLACE) ? 64'd0 : right_value;
		unique case (sz)
			SZ_8: begin
				m = 64'hFF;
				ls = {{56{left_value[7]}}, left_value[7:0]};
				rs = {{56{r_eff[7]}}, r_eff[7:0]};
				min_s = {{57{1'b1}}, 7'd0};
			end
			SZ_16: begin
				m = 64'hFFFF;
				ls = {{48{left_value[15]}}, left_value[15:0]};
				rs = {{48{r_eff[15]}}, r_eff[15:0]};
				min_s = {{49{1'b1}}, 15'd0};
			end
			SZ_32: begin
				m = 64'hFFFF_FFFF;
				ls = {{32{left_value[31]}}, left_value[31:0]};
				rs = {{32{r_eff[31]}}, r_eff[31:0]};
				min_s = {{33{1'b1}}, 31'd0};
			end
			default: begin
				m = '1;
				ls = left_value;
				rs = r_eff;
				min_s = {1'b1, 63'd0};
			end
		endcase
		lt = left_value & m;
		rt = r_eff & m;
		c = r_eff[5:0];
		is_sdiv = (mode == OP_SDIV) || (mode == OP_SMOD);
		is_udiv = (mode == OP_UDIV) || (mode == OP_UMOD);
		ovf = (ls == min_s) && (rs == '1);
		ma = ls[63] ? (64'd0 - ls) : ls;
		mb = rs[63] ? (64'd0 - rs) : rs;

		res = '0;
		case (mode)
			OP_ADD:    res = promote_wrap(lt + rt, sz);
			OP_SUB:    res = promote_wrap(lt - rt, sz);
			OP_AND:    res = left_value & r_eff;
			OP_OR:     res = left_value | r_eff;
			OP_XOR:    res = left_value ^ r_eff;
			OP_SHL:    res = promote_wrap(lt << c, sz);
			OP_SHR:    res = lt >> c;
			OP_SAR:    res = $unsigned($signed(ls) >>> c);
			OP_EQ:     res = {63'd0, lt == rt};
			OP_SGT:    res = {63'd0, $signed(ls) > $signed(rs)};
			OP_SLT:    res = {63'd0, $signed(ls) < $signed(rs)};
			OP_UGT:    res = {63'd0, lt > rt};
			OP_ULT:    res = {63'd0, lt < rt};
			OP_BOR:    res = {63'd0, (lt != 0) || (rt != 0)};
			OP_BAND:   res = {63'd0, (lt != 0) && (rt != 0)};
			OP_TOBOOL: res = {63'd0, lt != 0};
			OP_NEG:    res = 64'd0 - lt;
			OP_NOT:    res = ~left_value;
			OP_BNOT:   res = {63'd0, lt == 0};
			OP_ZEXT:   res = lt;
			OP_SEXT:   res = ls;
			default:   res = '0;
		endcase

		nxt = '0;
		nxt.valid = in_valid;
		nxt.size = sz;
		nxt.simple = res;
		nxt.lt = lt;
		nxt.rt = rt;
		nxt.uns = (left_kind == KIND_UCONST) || (binary && right_kind == KIND_UCONST);
		if (mode > OP_SEXT || left_kind == KIND_OTHER) begin
			nxt.status = ST_NOT_FOLDED;
		end else if (left_kind == KIND_PLACE) begin
			nxt.status = ST_PLACEHOLDER;
		end else if (binary && right_kind == KIND_OTHER) begin
			nxt.status = ST_NOT_FOLDED;
		end else if ((is_sdiv || is_udiv) && rt == 0) begin
			nxt.status = ST_NOT_FOLDED;
		end else if (is_sdiv && ovf) begin
			nxt.status = ST_NOT_FOLDED;
		end else begin
			nxt.status = ST_FOLDED;
		end
		if (mode == OP_MUL) begin
			nxt.sel = SEL_MUL;
		end else if (mode == OP_SDIV || mode == OP_UDIV) begin
			nxt.sel = SEL_QUO;
		end else if (is_sdiv || is_udiv) begin
			nxt.sel = SEL_REM;
		end else begin
			nxt.sel = SEL_SIMPLE;
		end
		if (is_sdiv) begin
			nxt.dvd = ma;
			nxt.dvs = mb;
			nxt.q_neg = ls[63] ^ rs[63];
			nxt.r_neg = ls[63];
		end else begin
			nxt.dvd = lt;
			nxt.dvs = rt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ialu_mul.sv -----
// Two-stage 64-bit multiplier built from 32x32 partial products; carries the beat along.
// Depends on ialu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ialu_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ialu_pkg::ialu_op_t op_s1,
	output ialu_pkg::ialu_op_t op_s3
);
	import ialu_pkg::*;

	ialu_op_t op_s2;
	logic [63:0] pp_ll_s2;
	logic [31:0] pp_lh_s2, pp_hl_s2;
	logic [63:0] prod;
	ialu_op_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= '0;
		end else begin
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_ll_s2 <= {32'd0, op_s1.lt[31:0]} * {32'd0, op_s1.rt[31:0]};
		pp_lh_s2 <= 32'(op_s1.lt[31:0] * op_s1.rt[63:32]);
		pp_hl_s2 <= 32'(op_s1.lt[63:32] * op_s1.rt[31:0]);
	end

	always_comb begin
		prod = pp_ll_s2 + {pp_lh_s2 + pp_hl_s2, 32'd0};
		nxt = op_s2;
		if (op_s2.sel == SEL_MUL) begin
			nxt.simple = promote_wrap(prod, op_s2.size);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s3 <= '0;
		end else begin
			op_s3 <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ialu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; the beat rides along.
// Depends on ialu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ialu_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ialu_pkg::ialu_op_t op_in,
	output ialu_pkg::ialu_op_t op_out,
	output logic [63:0]        rem_out
);
	import ialu_pkg::*;

	ialu_op_t    pipe_op_s [DIV_STAGES];
	logic [63:0] pipe_rem_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		ialu_op_t    st_op;
		logic [63:0] st_rem;
		logic [64:0] trial, diff;
		logic        ge;
		ialu_op_t    nxt;

		if (k == 0) begin : g_first
			assign st_op = op_in;
			assign st_rem = '0;
		end else begin : g_next
			assign st_op = pipe_op_s[k - 1];
			assign st_rem = pipe_rem_s[k - 1];
		end

		always_comb begin
			trial = {st_rem, st_op.dvd[63]};
			diff = trial - {1'b0, st_op.dvs};
			ge = (trial >= {1'b0, st_op.dvs});
			nxt = st_op;
			nxt.dvd = {st_op.dvd[62:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_op_s[k] <= '0;
			end else begin
				pipe_op_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk) begin
			pipe_rem_s[k] <= ge ? diff[63:0] : trial[63:0];
		end
	end

	assign op_out = pipe_op_s[DIV_STAGES - 1];
	assign rem_out = pipe_rem_s[DIV_STAGES - 1];
endmodule
`default_nettype wire

// ----- hdl/integer_alu_multiwidth_top.sv -----
// One beat accepted every cycle.
// Beats pass in order through decode, multiplier, 64-stage divider and result register.
// busy is always low; results cannot be stalled and appear for exactly one cycle.
// Asynchronous active-low reset empties the pipeline; no result follows a reset.
// Top level of the multi-width integer ALU: decode, multiplier, divider, result stage.
// Depends on ialu_pkg, ialu_decode, ialu_mul and ialu_div.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_multiwidth_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  mode,
	input  wire logic [1:0]  size,
	input  wire logic [1:0]  left_kind,
	input  wire logic [1:0]  right_kind,
	input  wire logic [63:0] left_value,
	input  wire logic [63:0] right_value,
	output logic             done,
	output logic [63:0]      result_value,
	output logic             result_unsigned,
	output logic [1:0]       status
);
	import ialu_pkg::*;

	ialu_op_t op_s1, op_s3, op_dv;
	logic [63:0] rem_dv, val;

	assign busy = 1'b0;

	ialu_decode u_decode (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.mode(mode), .size(size), .left_kind(left_kind), .right_kind(right_kind),
		.left_value(left_value), .right_value(right_value), .op_s1(op_s1)
	);

	ialu_mul u_mul (.clk(clk), .arst_n(arst_n), .op_s1(op_s1), .op_s3(op_s3));

	ialu_div u_div (
		.clk(clk), .arst_n(arst_n), .op_in(op_s3), .op_out(op_dv), .rem_out(rem_dv)
	);

	always_comb begin
		case (op_dv.sel)
			SEL_QUO: val = op_dv.q_neg ? (64'd0 - op_dv.dvd) : op_dv.dvd;
			SEL_REM: val = op_dv.r_neg ? (64'd0 - rem_dv) : rem_dv;
			default: val = op_dv.simple;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= op_dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_dv.status == ST_FOLDED) begin
			result_value <= val;
			result_unsigned <= op_dv.uns;
		end else begin
			result_value <= '0;
			result_unsigned <= 1'b0;
		end
		status <= op_dv.status;
	end
endmodule
`default_nettype wire

// ----- hdl/ialu_checker.sv -----
// Port-level checker for the multi-width integer ALU, bound to the top level.
// Depends on ialu_pkg and integer_alu_multiwidth_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_alu_multiwidth_top_assert.svh"
module ialu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [63:0] result_value,
	input wire logic        result_unsigned,
	input wire logic [1:0]  status
);
	import ialu_pkg::*;

	`IALU_ASSERT_IMPLY(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
	`IALU_ASSERT_DELAY(a_latency, clk, arst_n, start, LATENCY, done, "result missing")
	`IALU_ASSERT_IMPLY(a_no_extra, clk, arst_n, done, $past(start, LATENCY), "spurious result")
	`IALU_ASSERT_IMPLY(a_unfolded_zero, clk, arst_n, done && status != ST_FOLDED,
		result_value == 64'd0 && !result_unsigned, "unfolded result not cleared")
endmodule

bind integer_alu_multiwidth_top ialu_checker u_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.result_value(result_value), .result_unsigned(result_unsigned), .status(status)
);
`default_nettype wire

// ----- bench/tb_integer_alu_multiwidth_top.sv -----
// Self-checking testbench for the multi-width integer ALU: predicts each result
// in a scoreboard class and compares it with the done beats. Depends on ialu_pkg.
`timescale 1ns / 1ps
module tb_integer_alu_multiwidth_top;
	import ialu_pkg::*;

	typedef struct {
		logic [63:0] value;
		logic        uns;
		logic [1:0]  st;
	} alu_result_t;

	class alu_scoreboard;
		alu_result_t pending[$];
		int errors;
		int checked;

		function logic [63:0] wmask(logic [1:0] sz);
			case (sz)
				SZ_8: return 64'hFF;
				SZ_16: return 64'hFFFF;
				SZ_32: return 64'hFFFF_FFFF;
				default: return '1;
			endcase
		endfunction

		function logic [63:0] sext(logic [63:0] v, logic [1:0] sz);
			logic [63:0] m;
			logic [63:0] sb;
			m = wmask(sz);
			sb = (m >> 1) + 64'd1;
			return ((v & m) ^ sb) - sb;
		endfunction

		function logic [63:0] narrow(logic [63:0] v, logic [1:0] sz);
			if (sz == SZ_8 || sz == SZ_16)
				return {{32{v[31]}}, v[31:0]};
			if (sz == SZ_32)
				return {32'd0, v[31:0]};
			return v;
		endfunction

		function alu_result_t compute(logic [4:0] md, logic [1:0] sz, logic [1:0] lk,
				logic [1:0] rk, logic [63:0] l, logic [63:0] r);
			alu_result_t o;
			logic [63:0] m, lt, rt, ls, rs, ma, mb, q, res;
			logic [5:0] c;
			logic uns;
			o.value = '0;
			o.uns = 1'b0;
			o.st = ST_NOT_FOLDED;
			if (md > OP_SEXT)
				return o;
			if (lk == KIND_PLACE) begin
				o.st = ST_PLACEHOLDER;
				return o;
			end
			if (lk == KIND_OTHER)
				return o;
			uns = (lk == KIND_UCONST);
			if (md <= OP_BAND) begin
				if (rk == KIND_OTHER)
					return o;
				if (rk == KIND_PLACE)
					r = '0;
				if (rk == KIND_UCONST)
					uns = 1'b1;
			end
			m = wmask(sz);
			lt = l & m;
			rt = r & m;
			ls = sext(l, sz);
			rs = sext(r, sz);
			c = r[5:0];
			res = '0;
			case (md)
				OP_ADD: res = narrow(lt + rt, sz);
				OP_SUB: res = narrow(lt - rt, sz);
				OP_MUL: res = narrow(lt * rt, sz);
				OP_SDIV, OP_SMOD: begin
					if (rt == 0 || (ls == sext((m >> 1) + 64'd1, sz) && rs == '1))
						return o;
					ma = ls[63] ? -ls : ls;
					mb = rs[63] ? -rs : rs;
					if (md == OP_SDIV) begin
						q = ma / mb;
						res = (ls[63] != rs[63]) ? -q : q;
					end else begin
						q = ma % mb;
						res = ls[63] ? -q : q;
					end
				end
				OP_UDIV, OP_UMOD: begin
					if (rt == 0)
						return o;
					res = (md == OP_UDIV) ? lt / rt : lt % rt;
				end
				OP_AND: res = l & r;
				OP_OR: res = l | r;
				OP_XOR: res = l ^ r;
				OP_SHL: res = narrow(lt << c, sz);
				OP_SHR: res = lt >> c;
				OP_SAR: res = $unsigned($signed(ls) >>> c);
				OP_EQ: res = {63'd0, lt == rt};
				OP_SGT: res = {63'd0, $signed(ls) > $signed(rs)};
				OP_SLT: res = {63'd0, $signed(ls) < $signed(rs)};
				OP_UGT: res = {63'd0, lt > rt};
				OP_ULT: res = {63'd0, lt < rt};
				OP_BOR: res = {63'd0, (lt != 0 || rt != 0)};
				OP_BAND: res = {63'd0, (lt != 0 && rt != 0)};
				OP_TOBOOL: res = {63'd0, lt != 0};
				OP_NEG: res = -lt;
				OP_NOT: res = ~l;
				OP_BNOT: res = {63'd0, lt == 0};
				OP_ZEXT: res = lt;
				default: res = ls;
			endcase
			o.value = res;
			o.uns = uns;
			o.st = ST_FOLDED;
			return o;
		endfunction

		function void note_beat(logic [4:0] md, logic [1:0] sz, logic [1:0] lk,
				logic [1:0] rk, logic [63:0] l, logic [63:0] r);
			pending.push_back(compute(md, sz, lk, rk, l, r));
		endfunction

		function void check_result(logic [63:0] v, logic u, logic [1:0] s);
			alu_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: value %h status %0d", $time, v, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (v !== e.value) begin
				$display("%0t: result_value expected %h actual %h", $time, e.value, v);
				errors++;
			end
			if (u !== e.uns) begin
				$display("%0t: result_unsigned expected %0d actual %0d", $time, e.uns, u);
				errors++;
			end
			if (s !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, s);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [4:0] mode = 0;
	logic [1:0] size = 0;
	logic [1:0] left_kind = 0;
	logic [1:0] right_kind = 0;
	logic [63:0] left_value = 0;
	logic [63:0] right_value = 0;
	logic done;
	logic [63:0] result_value;
	logic result_unsigned;
	logic [1:0] status;

	alu_scoreboard sb = new();
	int cycles = 0;
	int idle_pct = 0;
	int sent = 0;

	integer_alu_multiwidth_top DUT (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && start && !busy) begin
			sb.note_beat(mode, size, left_kind, right_kind, left_value, right_value);
			sent++;
		end
		if (arst_n && done)
			sb.check_result(result_value, result_unsigned, status);
		if (cycles > 200000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
			3: v = 64'($urandom_range(0, 70));
			4: v = 64'd0 - 64'($urandom_range(1, 3));
			5: v = {{32{$urandom_range(0, 1) == 1}}, $urandom};
			default: ;
		endcase
		return v;
	endfunction

	task send_op(logic [4:0] md, logic [1:0] sz, logic [1:0] lk, logic [1:0] rk,
			logic [63:0] l, logic [63:0] r);
		while ($urandom_range(1, 100) <= idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		mode <= md;
		size <= sz;
		left_kind <= lk;
		right_kind <= rk;
		left_value <= l;
		right_value <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task send_random();
		logic [1:0] lk;
		logic [1:0] rk;
		lk = 2'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1));
		rk = 2'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1));
		send_op(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)), lk, rk,
			rand64(), rand64());
	endtask

	task drain();
		start <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int k;
		int sz;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (k = 0; k <= 31; k++)
			send_op(5'(k), 2'(k % 4), KIND_SCONST, k[0] ? KIND_UCONST : KIND_SCONST,
				'1, 64'd3);
		for (sz = 0; sz < 4; sz++) begin
			send_op(OP_SDIV, 2'(sz), KIND_SCONST, KIND_SCONST, 64'h8000_0000_0000_0000 >>
				(64 - 8 * (1 << sz)), '1);
			send_op(OP_SMOD, 2'(sz), KIND_SCONST, KIND_SCONST, 64'd7, 64'd0);
			send_op(OP_UDIV, 2'(sz), KIND_SCONST, KIND_SCONST, 64'd7, 64'h100_0000_0000);
		end
		send_op(OP_ADD, SZ_64, KIND_PLACE, KIND_SCONST, 64'd1, 64'd1);
		send_op(OP_ADD, SZ_64, KIND_OTHER, KIND_SCONST, 64'd1, 64'd1);
		send_op(OP_ADD, SZ_64, KIND_SCONST, KIND_OTHER, 64'd1, 64'd1);
		send_op(OP_SUB, SZ_8, KIND_SCONST, KIND_PLACE, 64'd5, 64'd9);
		send_op(OP_NEG, SZ_8, KIND_SCONST, KIND_OTHER, 64'h80, 64'd0);
		send_op(OP_SHL, SZ_16, KIND_SCONST, KIND_SCONST, 64'hFFFF, 64'd79);
		send_op(OP_SAR, SZ_32, KIND_SCONST, KIND_SCONST, 64'h8000_0000, 64'd127);
		send_op(OP_SEXT, SZ_64, KIND_UCONST, KIND_SCONST, 64'h8000_0000_0000_0001, 64'd0);
		drain();
		for (k = 0; k < 600; k++) begin
			case (k / 120)
				0: idle_pct = 0;
				1: idle_pct = 85;
				2: idle_pct = 22;
				default: idle_pct = $urandom_range(0, 30);
			endcase
			if (k == 300)
				drain();
			send_random();
		end
		drain();
		repeat (LATENCY + 10) @(negedge clk);
		$display("Sent %0d beats and checked %0d results over all modes, widths and kinds,",
			sent, sb.checked);
		$display("with idle phases from none to 85 percent.");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/ialu_pkg.sv
hdl/ialu_decode.sv
hdl/ialu_mul.sv
hdl/ialu_div.sv
hdl/integer_alu_multiwidth_top.sv
hdl/ialu_checker.sv
bench/tb_integer_alu_multiwidth_top.sv
